[rtl/core/sfdst_pkg.sv]
`default_nettype none

package sfdst_pkg;

  // Field and register widths.
  localparam int unsigned TIME_W    = 63;
  localparam int unsigned WIN_W     = 16;
  localparam int unsigned THR_W     = 16;
  localparam int unsigned BIT_W     = 5;
  localparam int unsigned VER_W     = 32;
  localparam int unsigned MTP_W     = 32;
  localparam int unsigned HEIGHT_W  = 32;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned ATT_W     = 16;
  localparam int unsigned IDX_W     = 3;

  // Threshold datapath widths: attempt + 1 needs 17 bits, its square 34,
  // the product with the window 50. The divisor is falloff times 100.
  localparam int unsigned ASEL_W    = ATT_W + 1;
  localparam int unsigned SQ_W      = 2 * ASEL_W;
  localparam int unsigned PROD_W    = SQ_W + WIN_W;
  localparam int unsigned DSR_W     = 23;
  localparam int unsigned DVD_W     = HEIGHT_W + 1;
  localparam int unsigned STEP_W    = 6;

  localparam logic [6:0]        DECAY_SCALE = 7'd100;
  localparam logic [STEP_W-1:0] MOD_STEPS   = STEP_W'(DVD_W);
  localparam logic [STEP_W-1:0] THR_STEPS   = STEP_W'(THR_W);
  localparam logic [2:0]        TOP_FIELD   = 3'b001;

  // Register reset values.
  localparam logic [TIME_W-1:0] START_TIME_RST   = '0;
  localparam logic [TIME_W-1:0] TIMEOUT_TIME_RST = '1;
  localparam logic [WIN_W-1:0]  WINDOW_RST       = 16'd2016;
  localparam logic [THR_W-1:0]  DEFAULT_THR_RST  = 16'd1916;

  typedef enum logic [2:0] {
    ST_DEFINED   = 3'd0,
    ST_STARTED   = 3'd1,
    ST_LOCKED_IN = 3'd2,
    ST_ACTIVE    = 3'd3,
    ST_FAILED    = 3'd4
  } sfdst_phase_e;

  typedef enum logic [IDX_W-1:0] {
    CFG_START_TIME   = 3'd0,
    CFG_TIMEOUT_TIME = 3'd1,
    CFG_WINDOW_SIZE  = 3'd2,
    CFG_THR_INITIAL  = 3'd3,
    CFG_THR_FLOOR    = 3'd4,
    CFG_FALLOFF      = 3'd5,
    CFG_DEFAULT_THR  = 3'd6,
    CFG_SIGNAL_BIT   = 3'd7
  } sfdst_cfg_idx_e;

  typedef enum logic [3:0] {
    C_IDLE,
    C_MOD,
    C_CAPT,
    C_ROUTE,
    C_SQ,
    C_MUL,
    C_CHK,
    C_TDIV,
    C_FIN,
    C_APPLY,
    C_EMIT
  } sfdst_ctrl_e;

  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] timeout_time;
    logic [WIN_W-1:0]  window_size;
    logic [THR_W-1:0]  threshold_initial;
    logic [THR_W-1:0]  threshold_floor;
    logic [THR_W-1:0]  falloff_coefficient;
    logic [THR_W-1:0]  default_threshold;
    logic [BIT_W-1:0]  signal_bit;
  } sfdst_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // take a word, start the next height modulo window division
    logic div_step;  // one restoring division step
    logic capt;      // keep the remainder as the period position
    logic vote_sel;  // threshold for the vote (attempt + 1) instead of the output
    logic sq;        // square the attempt
    logic mul;       // times the window, load the decay divisor
    logic chk;       // saturation check, start the quotient division
    logic fin;       // form the threshold
    logic apply;     // advance the deployment state
    logic emit;      // load the output register
  } sfdst_cmd_t;

  typedef struct packed {
    logic div_done;
    logic need_vote;
  } sfdst_sts_t;

endpackage

`default_nettype wire

[rtl/core/sfdst_ctrl.sv]
`default_nettype none

module sfdst_ctrl import sfdst_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire sfdst_sts_t sts_i,
  output sfdst_cmd_t      cmd_o
);

  sfdst_ctrl_e state_q, state_d;
  logic        vote_q, vote_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= C_IDLE;
      vote_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vote_q      <= vote_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    vote_d     = vote_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.vote_sel = vote_q;
    case (state_q)
      C_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = C_MOD;
        end
      end
      C_MOD: begin
        if (sts_i.div_done) begin
          state_d = C_CAPT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      C_CAPT: begin
        cmd_o.capt = 1'b1;
        state_d    = C_ROUTE;
      end
      C_ROUTE: begin
        if (sts_i.need_vote) begin
          vote_d  = 1'b1;
          state_d = C_SQ;
        end else begin
          state_d = C_APPLY;
        end
      end
      C_SQ: begin
        cmd_o.sq = 1'b1;
        state_d  = C_MUL;
      end
      C_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = C_CHK;
      end
      C_CHK: begin
        cmd_o.chk = 1'b1;
        state_d   = C_TDIV;
      end
      C_TDIV: begin
        if (sts_i.div_done) begin
          state_d = C_FIN;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      C_FIN: begin
        cmd_o.fin = 1'b1;
        if (vote_q) begin
          vote_d  = 1'b0;
          state_d = C_APPLY;
        end else begin
          state_d = C_EMIT;
        end
      end
      C_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = C_SQ;
      end
      C_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = C_IDLE;
        end
      end
      default: begin
        state_d = C_IDLE;
        vote_d  = 1'b0;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.emit;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[rtl/core/sfdst_dp.sv]
`default_nettype none

module sfdst_dp import sfdst_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sfdst_cfg_t          cfg_i,
  input  wire sfdst_cmd_t          cmd_i,
  output sfdst_sts_t               sts_o,
  input  wire logic [VER_W-1:0]    block_version_i,
  input  wire logic [MTP_W-1:0]    median_time_i,
  output logic [2:0]               deployment_state_o,
  output logic [CNT_W-1:0]         period_signal_count_o,
  output logic [WIN_W-1:0]         period_elapsed_o,
  output logic [THR_W-1:0]         current_threshold_o,
  output logic                     lock_possible_o,
  output logic [HEIGHT_W-1:0]      state_since_height_o
);

  // Deployment tracker state.
  sfdst_phase_e          phase_q, phase_d;
  logic [HEIGHT_W-1:0]   height_q;
  logic [CNT_W-1:0]      tally_q;
  logic [ATT_W-1:0]      attempt_q, attempt_d;
  logic [HEIGHT_W-1:0]   entered_q;

  // Working registers.
  logic [MTP_W-1:0]      mtp_q;
  logic [WIN_W-1:0]      elapsed_q;
  logic [SQ_W-1:0]       sq_q;
  logic [PROD_W-1:0]     prod_q;
  logic                  sat_q;
  logic [THR_W-1:0]      thr_q, thr_d;

  // Shared restoring divider.
  logic [DSR_W-1:0]      rem_q;
  logic [DVD_W-1:0]      dvd_q;
  logic [DSR_W-1:0]      dsr_q;
  logic [THR_W-1:0]      quo_q;
  logic [STEP_W-1:0]     cnt_q;

  // Output register.
  logic [2:0]            o_state_q;
  logic [CNT_W-1:0]      o_count_q;
  logic [WIN_W-1:0]      o_elapsed_q;
  logic [THR_W-1:0]      o_thr_q;
  logic                  o_lock_q;
  logic [HEIGHT_W-1:0]   o_since_q;

  logic [WIN_W-1:0]      p_eff;
  logic                  sig;
  logic [DSR_W:0]        rem_sh;
  logic                  div_ge;
  logic [DSR_W-1:0]      rem_sub;
  logic                  before_start;
  logic                  timed_out;
  logic                  period_end;
  logic [ASEL_W-1:0]     a_sel;
  logic [THR_W-1:0]      thr_diff;
  logic [WIN_W+1:0]      slack;
  logic [WIN_W+1:0]      missed;

  assign p_eff = (cfg_i.window_size == '0) ? WIN_W'(1) : cfg_i.window_size;

  assign sig = (block_version_i[VER_W-1 -: 3] == TOP_FIELD) &&
               block_version_i[cfg_i.signal_bit];

  // The remainder always stays below the divisor, so the difference fits.
  assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
  assign div_ge  = rem_sh >= {1'b0, dsr_q};
  assign rem_sub = rem_sh[DSR_W-1:0] - dsr_q;

  assign before_start = {{(TIME_W-MTP_W){1'b0}}, mtp_q} <  cfg_i.start_time;
  assign timed_out    = {{(TIME_W-MTP_W){1'b0}}, mtp_q} >= cfg_i.timeout_time;
  assign period_end   = (elapsed_q == '0);

  assign sts_o.div_done  = (cnt_q == '0);
  assign sts_o.need_vote = period_end && !before_start && !timed_out &&
                           (phase_q == ST_STARTED);

  always_comb begin
    if (cmd_i.vote_sel) begin
      a_sel = {1'b0, attempt_q} + ASEL_W'(1);
    end else if (phase_q == ST_STARTED) begin
      a_sel = {1'b0, attempt_q};
    end else begin
      a_sel = '0;
    end
  end

  // Threshold: default, initial, or decayed from saturation and quotient.
  assign thr_diff = cfg_i.threshold_initial - quo_q;
  always_comb begin
    if (cfg_i.threshold_initial == '0) begin
      thr_d = cfg_i.default_threshold;
    end else if (cfg_i.threshold_floor == '0 || cfg_i.falloff_coefficient == '0) begin
      thr_d = cfg_i.threshold_initial;
    end else if (sat_q || quo_q >= cfg_i.threshold_initial) begin
      thr_d = cfg_i.threshold_floor;
    end else if (thr_diff < cfg_i.threshold_floor) begin
      thr_d = cfg_i.threshold_floor;
    end else begin
      thr_d = thr_diff;
    end
  end

  // State advance at the last word of a period.
  always_comb begin
    phase_d = phase_q;
    if (period_end) begin
      if (before_start) begin
        phase_d = ST_DEFINED;
      end else begin
        case (phase_q)
          ST_DEFINED:   phase_d = timed_out ? ST_FAILED : ST_STARTED;
          ST_STARTED: begin
            if (timed_out) begin
              phase_d = ST_FAILED;
            end else if (tally_q >= thr_q) begin
              phase_d = ST_LOCKED_IN;
            end
          end
          ST_LOCKED_IN: phase_d = ST_ACTIVE;
          default:      phase_d = phase_q;
        endcase
      end
    end
    if (phase_d == ST_STARTED) begin
      if (phase_q != ST_STARTED) begin
        attempt_d = '0;
      end else if (attempt_q != '1) begin
        attempt_d = attempt_q + ATT_W'(1);
      end else begin
        attempt_d = attempt_q;
      end
    end else begin
      attempt_d = '0;
    end
  end

  assign slack  = {2'b00, p_eff} - {2'b00, thr_q};
  assign missed = {2'b00, elapsed_q} - {2'b00, tally_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ST_DEFINED;
      height_q  <= '0;
      tally_q   <= '0;
      attempt_q <= '0;
      entered_q <= '0;
      cnt_q     <= '0;
    end else begin
      if (cmd_i.load) begin
        tally_q <= tally_q + CNT_W'(sig);
        cnt_q   <= MOD_STEPS;
      end else if (cmd_i.chk) begin
        cnt_q   <= THR_STEPS;
      end else if (cmd_i.div_step) begin
        cnt_q   <= cnt_q - STEP_W'(1);
      end
      if (cmd_i.apply) begin
        if (period_end && phase_d != phase_q) begin
          entered_q <= height_q + HEIGHT_W'(1);
        end
        if (period_end) begin
          phase_q   <= phase_d;
          attempt_q <= attempt_d;
          tally_q   <= '0;
        end
        height_q <= height_q + HEIGHT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mtp_q <= median_time_i;
      dvd_q <= {1'b0, height_q} + DVD_W'(1);
      rem_q <= '0;
      dsr_q <= {{(DSR_W-WIN_W){1'b0}}, p_eff};
    end else if (cmd_i.mul) begin
      dsr_q <= DSR_W'(cfg_i.falloff_coefficient) * DSR_W'(DECAY_SCALE);
    end else if (cmd_i.chk) begin
      // The quotient only matters below 2^16: the top part of the
      // product then already lies below the divisor.
      rem_q <= prod_q[THR_W +: DSR_W];
      dvd_q <= {prod_q[THR_W-1:0], {(DVD_W-THR_W){1'b0}}};
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? rem_sub : rem_sh[DSR_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      quo_q <= {quo_q[THR_W-2:0], div_ge};
    end
    if (cmd_i.capt) begin
      elapsed_q <= rem_q[WIN_W-1:0];
    end
    if (cmd_i.sq) begin
      sq_q <= SQ_W'(a_sel) * SQ_W'(a_sel);
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(sq_q) * PROD_W'(p_eff);
    end
    if (cmd_i.chk) begin
      sat_q <= prod_q[PROD_W-1:THR_W] >= {{(PROD_W-THR_W-DSR_W){1'b0}}, dsr_q};
    end
    if (cmd_i.fin) begin
      thr_q <= thr_d;
    end
    if (cmd_i.emit) begin
      o_state_q   <= phase_q;
      o_count_q   <= tally_q;
      o_elapsed_q <= elapsed_q;
      o_thr_q     <= thr_q;
      o_lock_q    <= $signed(slack) >= $signed(missed);
      o_since_q   <= (phase_q == ST_DEFINED) ? '0 : entered_q;
    end
  end

  assign deployment_state_o    = o_state_q;
  assign period_signal_count_o = o_count_q;
  assign period_elapsed_o      = o_elapsed_q;
  assign current_threshold_o   = o_thr_q;
  assign lock_possible_o       = o_lock_q;
  assign state_since_height_o  = o_since_q;

endmodule

`default_nettype wire

[rtl/core/soft_fork_deployment_state_tracker_top.sv]
// Flow: one word at a time, taken in idle; it gets its period position and result
//   threshold, at the end of a started period also the vote threshold.
// Throughput: set by the shared one-bit-a-step divider (33 steps for the period
//   position, 16 per decayed threshold) and by back-pressure on the result side.
// Reset: asynchronous, active low; state defined, height, tally, attempt and
//   entry height zero, registers at their documented defaults.
`default_nettype none

module soft_fork_deployment_state_tracker_top import sfdst_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration write port.
  input  wire logic                cfg_we_i,
  input  wire logic [IDX_W-1:0]    cfg_idx_i,
  input  wire logic [TIME_W-1:0]   cfg_wdata_i,
  // Input words: one block header summary each, in height order.
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [VER_W-1:0]    block_version_i,
  input  wire logic [MTP_W-1:0]    median_time_i,
  // Result words.
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [2:0]               deployment_state_o,
  output logic [CNT_W-1:0]         period_signal_count_o,
  output logic [WIN_W-1:0]         period_elapsed_o,
  output logic [THR_W-1:0]         current_threshold_o,
  output logic                     lock_possible_o,
  output logic [HEIGHT_W-1:0]      state_since_height_o
);

  // The configuration registers live here and feed the datapath as one
  // struct. Writes are only expected while the tracker is idle, so no
  // shadow copy is kept for a word in flight.
  sfdst_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_time          <= START_TIME_RST;
      cfg_q.timeout_time        <= TIMEOUT_TIME_RST;
      cfg_q.window_size         <= WINDOW_RST;
      cfg_q.threshold_initial   <= '0;
      cfg_q.threshold_floor     <= '0;
      cfg_q.falloff_coefficient <= '0;
      cfg_q.default_threshold   <= DEFAULT_THR_RST;
      cfg_q.signal_bit          <= '0;
    end else if (cfg_we_i) begin
      case (sfdst_cfg_idx_e'(cfg_idx_i))
        CFG_START_TIME:   cfg_q.start_time          <= cfg_wdata_i;
        CFG_TIMEOUT_TIME: cfg_q.timeout_time        <= cfg_wdata_i;
        CFG_WINDOW_SIZE:  cfg_q.window_size         <= cfg_wdata_i[WIN_W-1:0];
        CFG_THR_INITIAL:  cfg_q.threshold_initial   <= cfg_wdata_i[THR_W-1:0];
        CFG_THR_FLOOR:    cfg_q.threshold_floor     <= cfg_wdata_i[THR_W-1:0];
        CFG_FALLOFF:      cfg_q.falloff_coefficient <= cfg_wdata_i[THR_W-1:0];
        CFG_DEFAULT_THR:  cfg_q.default_threshold   <= cfg_wdata_i[THR_W-1:0];
        CFG_SIGNAL_BIT:   cfg_q.signal_bit          <= cfg_wdata_i[BIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The controller walks each word through: period position by division of
  // the next height by the window, an optional vote threshold, the state
  // advance, the threshold for the result, and finally the output register.
  // The output register lets the next word come in while a result waits;
  // a result that is still held there keeps the following one waiting.
  sfdst_cmd_t cmd;
  sfdst_sts_t sts;

  sfdst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the deployment state, a squaring and a window
  // multiply for the decay term, and one restoring divider shared by the
  // modulo and the decay quotient.
  sfdst_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_i                 (cfg_q),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .block_version_i       (block_version_i),
    .median_time_i         (median_time_i),
    .deployment_state_o    (deployment_state_o),
    .period_signal_count_o (period_signal_count_o),
    .period_elapsed_o      (period_elapsed_o),
    .current_threshold_o   (current_threshold_o),
    .lock_possible_o       (lock_possible_o),
    .state_since_height_o  (state_since_height_o)
  );

  // One word at a time: right after taking a word the tracker is busy.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("tracker took a second word while busy");

  // A deployment still in its defined state reports no entry height.
  a_defined_no_height: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && deployment_state_o == ST_DEFINED) |-> (state_since_height_o == '0))
    else $error("defined state with nonzero entry height");

  // The last word of a period clears the signalling tally.
  a_period_end_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && period_elapsed_o == '0) |-> (period_signal_count_o == '0))
    else $error("signal tally not cleared at period end");

endmodule

`default_nettype wire

[sim/testbench.sv]
import sfdst_pkg::*;

// One result word: the deployment state for the next block and the
// statistics of the period that is under way.
typedef struct packed {
  logic [2:0]          state;
  logic [CNT_W-1:0]    signals;
  logic [WIN_W-1:0]    elapsed;
  logic [THR_W-1:0]    threshold;
  logic                lock_possible;
  logic [HEIGHT_W-1:0] since;
} period_report_t;

// Tracks the deployment state machine on its own copy of the registers and
// holds the reports that the block still owes, oldest first.
class deployment_ledger;
  sfdst_cfg_t          regs;
  sfdst_phase_e        phase;
  logic [HEIGHT_W-1:0] height;
  logic [HEIGHT_W-1:0] entered;
  logic [CNT_W-1:0]    tally;
  logic [ATT_W-1:0]    attempts;
  period_report_t      awaited_reports[$];
  int                  mismatches;

  function new();
    regs.start_time          = START_TIME_RST;
    regs.timeout_time        = TIMEOUT_TIME_RST;
    regs.window_size         = WINDOW_RST;
    regs.threshold_initial   = '0;
    regs.threshold_floor     = '0;
    regs.falloff_coefficient = '0;
    regs.default_threshold   = DEFAULT_THR_RST;
    regs.signal_bit          = '0;
    phase      = ST_DEFINED;
    height     = '0;
    entered    = '0;
    tally      = '0;
    attempts   = '0;
    mismatches = 0;
  endfunction

  function void write_reg(sfdst_cfg_idx_e idx, logic [TIME_W-1:0] word);
    case (idx)
      CFG_START_TIME:   regs.start_time          = word;
      CFG_TIMEOUT_TIME: regs.timeout_time        = word;
      CFG_WINDOW_SIZE:  regs.window_size         = word[WIN_W-1:0];
      CFG_THR_INITIAL:  regs.threshold_initial   = word[THR_W-1:0];
      CFG_THR_FLOOR:    regs.threshold_floor     = word[THR_W-1:0];
      CFG_FALLOFF:      regs.falloff_coefficient = word[THR_W-1:0];
      CFG_DEFAULT_THR:  regs.default_threshold   = word[THR_W-1:0];
      default:          regs.signal_bit          = word[BIT_W-1:0];
    endcase
  endfunction

  // A zero window behaves as a window of one block.
  function logic [WIN_W:0] window_span();
    return (regs.window_size == '0) ? (WIN_W+1)'(1) : {1'b0, regs.window_size};
  endfunction

  function logic [THR_W-1:0] threshold_at(logic [ATT_W:0] attempt);
    longint unsigned a;
    longint unsigned decay;
    if (regs.threshold_initial == '0) return regs.default_threshold;
    if (regs.threshold_floor == '0 || regs.falloff_coefficient == '0)
      return regs.threshold_initial;
    a = attempt;
    decay = a * a * window_span();
    decay = decay / DECAY_SCALE / regs.falloff_coefficient;
    if (decay >= regs.threshold_initial ||
        regs.threshold_initial - decay < regs.threshold_floor)
      return regs.threshold_floor;
    return THR_W'(regs.threshold_initial - decay);
  endfunction

  // Advances the chain by one accepted block and queues the report it owes.
  function void note_block(logic [VER_W-1:0] ver, logic [MTP_W-1:0] mtp);
    logic [WIN_W:0]      span;
    logic [HEIGHT_W-1:0] h;
    longint unsigned     next_h;
    logic [WIN_W-1:0]    pos;
    sfdst_phase_e        nxt;
    logic [THR_W-1:0]    thr;
    longint              slack;
    longint              missed;
    period_report_t      rep;
    span   = window_span();
    h      = height;
    next_h = h;
    next_h = next_h + 1;
    pos    = WIN_W'(next_h % span);
    if (ver[VER_W-1 -: 3] == TOP_FIELD && ver[regs.signal_bit]) tally = tally + 1'b1;
    if (pos == '0) begin
      nxt = phase;
      if (mtp < regs.start_time) begin
        nxt = ST_DEFINED;
      end else if (phase == ST_DEFINED) begin
        nxt = (mtp >= regs.timeout_time) ? ST_FAILED : ST_STARTED;
      end else if (phase == ST_STARTED) begin
        // The timeout wins over a successful vote.
        if (mtp >= regs.timeout_time) begin
          nxt = ST_FAILED;
        end else if (tally >= threshold_at({1'b0, attempts} + 1'b1)) begin
          nxt = ST_LOCKED_IN;
        end
      end else if (phase == ST_LOCKED_IN) begin
        nxt = ST_ACTIVE;
      end
      if (nxt == ST_STARTED && phase == ST_STARTED) begin
        if (attempts != '1) attempts = attempts + 1'b1;
      end else begin
        attempts = '0;
      end
      if (nxt != phase) entered = h + 1'b1;
      phase = nxt;
      tally = '0;
    end
    height = h + 1'b1;
    thr    = threshold_at((phase == ST_STARTED) ? {1'b0, attempts} : '0);
    slack  = longint'(span) - longint'(thr);
    missed = longint'(pos) - longint'(tally);
    rep.state         = phase;
    rep.signals       = tally;
    rep.elapsed       = pos;
    rep.threshold     = thr;
    rep.lock_possible = (slack >= missed);
    rep.since         = (phase == ST_DEFINED) ? '0 : entered;
    awaited_reports = {awaited_reports, rep};
  endfunction

  function int reports_due();
    return awaited_reports.size();
  endfunction

  function void compare_field(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  function void check_report(period_report_t got);
    period_report_t want;
    if (awaited_reports.size() == 0) begin
      $display("%0t: result word with none expected, actual state %0d height %0d",
               $time, got.state, got.since);
      mismatches++;
      return;
    end
    want = awaited_reports.pop_front();
    compare_field("deployment_state", want.state, got.state);
    compare_field("period_signal_count", want.signals, got.signals);
    compare_field("period_elapsed", want.elapsed, got.elapsed);
    compare_field("current_threshold", want.threshold, got.threshold);
    compare_field("lock_possible", want.lock_possible, got.lock_possible);
    compare_field("state_since_height", want.since, got.since);
  endfunction
endclass

module testbench;

  // Number of blocks in the random part of the chain.
  localparam int RANDOM_BLOCKS = 1450;
  // Blocks at the end of the run that go through without any idling.
  localparam int QUIET_TAIL    = 150;
  // Length of the one long hold-off on the result side.
  localparam int LONG_HOLD     = 400;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  sfdst_cfg_idx_e      cfg_idx;
  logic [TIME_W-1:0]   cfg_wdata;
  logic                in_valid;
  logic                in_ready_o;
  logic [VER_W-1:0]    block_version;
  logic [MTP_W-1:0]    median_time;
  logic                out_valid_o;
  logic                out_ready;
  logic [2:0]          deployment_state_o;
  logic [CNT_W-1:0]    period_signal_count_o;
  logic [WIN_W-1:0]    period_elapsed_o;
  logic [THR_W-1:0]    current_threshold_o;
  logic                lock_possible_o;
  logic [HEIGHT_W-1:0] state_since_height_o;

  deployment_ledger ledger;

  // Idling controls, written by the stimulus and read by send_block and the sink.
  bit sender_gaps   = 1'b0;
  bit sink_gaps     = 1'b0;
  bit quiet         = 1'b0;
  bit long_hold_req = 1'b0;

  always #5 clk_i = ~clk_i;

  soft_fork_deployment_state_tracker_top dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we),
    .cfg_idx_i             (cfg_idx),
    .cfg_wdata_i           (cfg_wdata),
    .in_valid_i            (in_valid),
    .in_ready_o            (in_ready_o),
    .block_version_i       (block_version),
    .median_time_i         (median_time),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready),
    .deployment_state_o    (deployment_state_o),
    .period_signal_count_o (period_signal_count_o),
    .period_elapsed_o      (period_elapsed_o),
    .current_threshold_o   (current_threshold_o),
    .lock_possible_o       (lock_possible_o),
    .state_since_height_o  (state_since_height_o)
  );

  function automatic logic [TIME_W-1:0] register_word(sfdst_cfg_t plan, sfdst_cfg_idx_e idx);
    case (idx)
      CFG_START_TIME:   return plan.start_time;
      CFG_TIMEOUT_TIME: return plan.timeout_time;
      CFG_WINDOW_SIZE:  return TIME_W'(plan.window_size);
      CFG_THR_INITIAL:  return TIME_W'(plan.threshold_initial);
      CFG_THR_FLOOR:    return TIME_W'(plan.threshold_floor);
      CFG_FALLOFF:      return TIME_W'(plan.falloff_coefficient);
      CFG_DEFAULT_THR:  return TIME_W'(plan.default_threshold);
      default:          return TIME_W'(plan.signal_bit);
    endcase
  endfunction

  // Registers are only written with the block idle, so the task first waits
  // until every owed report has come back, then writes all eight registers
  // on consecutive edges.
  task automatic load_settings(input sfdst_cfg_t plan);
    sfdst_cfg_idx_e    idx;
    logic [TIME_W-1:0] word;
    while (ledger.reports_due() != 0) @(posedge clk_i);
    idx = idx.first();
    do begin
      word = register_word(plan, idx);
      cfg_we    <= 1'b1;
      cfg_idx   <= idx;
      cfg_wdata <= word;
      @(posedge clk_i);
      ledger.write_reg(idx, word);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_we <= 1'b0;
  endtask

  // Offers one block and returns at the edge where it is taken. Valid stays
  // high afterwards; the caller lowers it when the chain stops. The gap before
  // a block is made of several short bursts, so that it can end anywhere in
  // the block's processing of the previous word.
  task automatic send_block(input logic [VER_W-1:0] ver, input logic [MTP_W-1:0] mtp);
    int gap;
    gap = 0;
    if (sender_gaps && !quiet) begin
      while ($urandom_range(0, 6) != 0) gap += $urandom_range(1, 8);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    block_version <= ver;
    median_time   <= mtp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    ledger.note_block(ver, mtp);
  endtask

  // Result side: checks every accepted word and decides ready for the next
  // cycle. Ready drops in random bursts, and once, on request, for a long
  // stretch while the sender keeps offering, which backs the block up.
  initial begin : result_sink
    int             burst;
    int             hold_left;
    bit             hold_taken;
    bit             ready_nxt;
    period_report_t got;
    burst      = 0;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready) begin
        got.state         = deployment_state_o;
        got.signals       = period_signal_count_o;
        got.elapsed       = period_elapsed_o;
        got.threshold     = current_threshold_o;
        got.lock_possible = lock_possible_o;
        got.since         = state_since_height_o;
        ledger.check_report(got);
      end
      if (long_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_nxt = 1'b0;
      end else if (burst > 0) begin
        burst--;
        ready_nxt = 1'b0;
      end else if (sink_gaps && !quiet && $urandom_range(0, 5) == 0) begin
        burst     = $urandom_range(1, 8) - 1;
        ready_nxt = 1'b0;
      end else begin
        ready_nxt = 1'b1;
      end
      out_ready <= ready_nxt;
    end
  end

  initial begin : stimulus
    sfdst_cfg_t       plan;
    int               random_blocks;
    int               chain_len;
    int               span;
    int               sig_pct;
    int               r;
    logic [MTP_W-1:0] mtp_lo;
    logic [MTP_W-1:0] mtp_hi;
    logic [VER_W-1:0] ver;
    logic [MTP_W-1:0] mtp;

    ledger = new();
    random_blocks  = 0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CFG_START_TIME;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    block_version <= '0;
    median_time   <= '0;
    rst_ni        <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers at their reset values: a long default window, so only the
    // period statistics move. Extremes of both input fields.
    send_block(32'h0000_0000, 32'h0000_0000);
    send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(32'h2000_0001, 32'h0000_03E8);
    send_block(32'h3FFF_FFFE, 32'h0000_0005);
    in_valid <= 1'b0;

    // A one-block window makes every block a period end. Start at 100 and
    // time out at 200; a single signal locks in.
    plan.start_time          = 63'd100;
    plan.timeout_time        = 63'd200;
    plan.window_size         = 16'd1;
    plan.threshold_initial   = 16'd1;
    plan.threshold_floor     = '0;
    plan.falloff_coefficient = '0;
    plan.default_threshold   = DEFAULT_THR_RST;
    plan.signal_bit          = '0;
    load_settings(plan);
    send_block(32'h2000_0001, 32'd99);   // before start: back to defined
    send_block(32'h0000_0000, 32'd100);  // defined to started right at start
    send_block(32'h2000_0001, 32'd150);  // vote reached: locked in
    send_block(32'h0000_0000, 32'd150);  // locked in always turns active
    send_block(32'h0000_0000, 32'd200);  // active is terminal past the timeout
    send_block(32'h2000_0001, 32'd50);   // before start undoes even active
    send_block(32'h0000_0000, 32'd120);
    send_block(32'h2000_0001, 32'd200);  // timeout is checked before the vote
    send_block(32'h0000_0000, 32'd0);
    send_block(32'h2000_0000, 32'd250);  // defined straight to failed
    send_block(32'h0000_0000, 32'd30);
    send_block(32'h0000_0000, 32'd100);
    send_block(32'h6000_0001, 32'd150);  // wrong top bits: no signal, retry
    in_valid <= 1'b0;

    // Zero window acts as one; a zero default threshold locks without any
    // signal; the signal bit sits inside the top field.
    plan.start_time          = '0;
    plan.timeout_time        = '1;
    plan.window_size         = '0;
    plan.threshold_initial   = '0;
    plan.default_threshold   = '0;
    plan.signal_bit          = 5'd29;
    load_settings(plan);
    send_block(32'h2000_0000, 32'hFFFF_FFFF);
    send_block(32'hE000_0000, 32'd7);
    send_block(32'h0000_0000, 32'd0);
    in_valid <= 1'b0;

    // Window and threshold registers at their top value; the signal bit
    // lands in the top field, where it can never signal.
    plan.window_size         = '1;
    plan.threshold_initial   = '1;
    plan.threshold_floor     = '1;
    plan.falloff_coefficient = '1;
    plan.default_threshold   = '1;
    plan.signal_bit          = 5'd31;
    load_settings(plan);
    send_block(32'h8000_0000, 32'h1234_5678);
    send_block(32'hA000_0000, 32'h8765_4321);
    in_valid <= 1'b0;

    // Random part: one settings draw per chain. Most windows are short so
    // that many periods end; most median times fall between start and
    // timeout so that the deployment lives through several votes.
    while (random_blocks < RANDOM_BLOCKS) begin
      r = $urandom_range(0, 99);
      if (r < 70)      plan.window_size = 16'($urandom_range(1, 8));
      else if (r < 80) plan.window_size = 16'($urandom_range(9, 40));
      else if (r < 88) plan.window_size = '0;
      else if (r < 94) plan.window_size = 16'($urandom_range(41, 300));
      else if (r < 97) plan.window_size = '1;
      else             plan.window_size = 16'($urandom_range(301, 65534));
      span = (plan.window_size == '0) ? 1 : int'(plan.window_size);

      r = $urandom_range(0, 99);
      if (r < 15)      plan.threshold_initial = '0;
      else if (r < 22) plan.threshold_initial = '1;
      else             plan.threshold_initial = 16'($urandom_range(1, span));
      r = $urandom_range(0, 99);
      if (r < 40)      plan.threshold_floor = '0;
      else if (r < 90) plan.threshold_floor = 16'($urandom_range(1, span));
      else             plan.threshold_floor = '1;
      r = $urandom_range(0, 99);
      if (r < 30)      plan.falloff_coefficient = '0;
      else if (r < 80) plan.falloff_coefficient = 16'($urandom_range(1, 3));
      else if (r < 90) plan.falloff_coefficient = 16'($urandom_range(4, 100));
      else             plan.falloff_coefficient = '1;
      r = $urandom_range(0, 99);
      if (r < 40)      plan.default_threshold = 16'($urandom_range(0, span));
      else if (r < 70) plan.default_threshold = DEFAULT_THR_RST;
      else if (r < 85) plan.default_threshold = '0;
      else             plan.default_threshold = '1;
      plan.signal_bit = ($urandom_range(0, 9) != 0) ? 5'($urandom_range(0, 28))
                                                    : 5'($urandom_range(29, 31));

      // Start and timeout: a 32-bit window around the median times mostly,
      // plus the corners of the 63-bit registers.
      r = $urandom_range(0, 99);
      if (r < 70) begin
        mtp_lo = $urandom_range(1, 32'hFE00_0000);
        mtp_hi = mtp_lo + $urandom_range(1, 32'h00FF_FFFF);
        plan.start_time   = TIME_W'(mtp_lo);
        plan.timeout_time = TIME_W'(mtp_hi);
        mtp_hi = mtp_hi - 1'b1;
      end else begin
        mtp_lo = '0;
        mtp_hi = '1;
        if (r < 78) begin
          plan.start_time   = '0;
          plan.timeout_time = '1;
        end else if (r < 84) begin
          plan.start_time   = TIME_W'({$urandom, $urandom});
          plan.timeout_time = TIME_W'({$urandom, $urandom});
        end else if (r < 89) begin
          plan.start_time   = '0;
          plan.timeout_time = '0;
        end else if (r < 94) begin
          plan.start_time   = '1;
          plan.timeout_time = '1;
        end else begin
          mtp_lo = $urandom;
          plan.start_time   = TIME_W'(mtp_lo);
          plan.timeout_time = TIME_W'({$urandom, $urandom});
        end
      end

      sig_pct = ($urandom_range(0, 9) < 6) ? $urandom_range(60, 100)
                                           : $urandom_range(0, 100);
      if (span <= 8)       chain_len = $urandom_range(8, 20) * span;
      else if (span <= 40) chain_len = $urandom_range(3, 5) * span;
      else                 chain_len = $urandom_range(10, 30);
      if (chain_len > RANDOM_BLOCKS - random_blocks)
        chain_len = RANDOM_BLOCKS - random_blocks;

      load_settings(plan);
      sender_gaps = ($urandom_range(0, 2) != 0);
      sink_gaps   = ($urandom_range(0, 2) != 0);
      // The first random chain also gets the long hold-off on the result side.
      long_hold_req = 1'b1;

      repeat (chain_len) begin
        ver = $urandom;
        r   = $urandom_range(0, 99);
        if (r < sig_pct) begin
          ver[VER_W-1 -: 3]     = TOP_FIELD;
          ver[plan.signal_bit]  = 1'b1;
        end else if ($urandom_range(0, 1) != 0) begin
          // Right top field, deployment bit clear.
          ver[VER_W-1 -: 3]     = TOP_FIELD;
          ver[plan.signal_bit]  = 1'b0;
        end
        r = $urandom_range(0, 99);
        if (r < 75) begin
          mtp = $urandom_range(mtp_lo, mtp_hi);
        end else if (r < 85) begin
          case ($urandom_range(0, 3))
            0:       mtp = mtp_lo - 1'b1;
            1:       mtp = mtp_lo;
            2:       mtp = mtp_hi;
            default: mtp = mtp_hi + 1'b1;
          endcase
        end else begin
          mtp = $urandom;
        end
        send_block(ver, mtp);
        random_blocks++;
        quiet = (random_blocks >= RANDOM_BLOCKS - QUIET_TAIL);
      end
      in_valid <= 1'b0;
    end

    // Drain, then give the block time to show any stray result word.
    while (ledger.reports_due() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (ledger.mismatches == 0) begin
      $display("[soft_fork_deployment_state_tracker_top] OK");
    end else begin
      $display("[soft_fork_deployment_state_tracker_top] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of the whole chain.
  initial begin : watchdog
    #10000000;
    $display("[soft_fork_deployment_state_tracker_top] ERROR");
    $finish;
  end

endmodule
